// ===== hdl/stable_min_priority_queue_unit_assert.svh =====
// ----------------------------------------------------------------------------
// stable_min_priority_queue_unit assertion macros
// Concurrent assertion wrappers for the priority queue unit; compiled out
// when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef STABLE_MIN_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define STABLE_MIN_PRIORITY_QUEUE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// expression must hold at every clock edge outside reset
`define SMPQ_ASSERT(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("smpq assertion failed");
// consequent must hold in the cycle of the antecedent
`define SMPQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smpq assertion failed");
`else
`define SMPQ_ASSERT(label, clk, rst_n, expr)
`define SMPQ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hdl/smpq_pkg.sv =====
// ----------------------------------------------------------------------------
// smpq_pkg
// Shared types and constants of the stable min priority queue unit.
// ----------------------------------------------------------------------------
package smpq_pkg;

    // default configuration
    localparam int DEPTH_DEF     = 16;
    localparam int PRIO_BITS_DEF = 16;
    localparam int ELEM_BITS_DEF = 16;

    // command codes
    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    // error codes
    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_FULL  = 2'd1;
    localparam logic [1:0] ERR_EMPTY = 2'd2;

    // input item
    typedef struct packed {
        logic        command;
        logic [15:0] elem;
        logic [15:0] priority_req;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [15:0] head_elem;
        logic [15:0] head_priority;
        logic        empty_res;
        logic [4:0]  count;
        logic [1:0]  error;
    } t_out_item;

    // controller to datapath commands
    typedef struct packed {
        logic       load_in;
        logic [1:0] err_code;
        logic       enq_init;
        logic       shift;
        logic       place;
        logic       deq;
        logic       head_load;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic empty;
        logic full;
        logic one_left;
        logic last;
        logic gt;
    } t_dp_status;

endpackage

// ===== hdl/stable_min_priority_queue_unit.sv =====
// ----------------------------------------------------------------------------
// stable_min_priority_queue_unit
// Bounded priority queue in sorted order; smaller priority first, equal
// priorities in arrival order.
// ----------------------------------------------------------------------------
// Usage:
//   An item (enqueue elem/priority_req, or dequeue the head) is taken at a
//   clock edge with start high and busy low. busy stays high until the
//   result has been shown.
//   Every item gives one result on o_result, valid for the single cycle in
//   which o_done is high: head entry, empty flag, count and error code.
//   The receiver cannot stall; the result is taken in that cycle.
//   Cycles from accept to o_done (the next item may be taken the cycle
//   after o_done):
//     full enqueue or empty dequeue        1
//     dequeue leaving the queue empty      1
//     other dequeue                        2 (head reload from the store)
//     enqueue into an empty queue          2
//     other enqueue                        s + 2, s = entries with a larger
//                                          priority, up to DEPTH - 1
//   Enqueue time is set by the insertion walk: one entry is moved back per
//   cycle through the single read and single write port of the entry store.
//   Reset (synchronous, active low) empties the queue at once.
// ----------------------------------------------------------------------------
module stable_min_priority_queue_unit #(
    parameter int DEPTH     = smpq_pkg::DEPTH_DEF,
    parameter int PRIO_BITS = smpq_pkg::PRIO_BITS_DEF,
    parameter int ELEM_BITS = smpq_pkg::ELEM_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  smpq_pkg::t_in_item  i_item,
    output logic                busy,
    output logic                o_done,
    output smpq_pkg::t_out_item o_result
);

    smpq_pkg::t_dp_cmd    dp_cmd;
    smpq_pkg::t_dp_status dp_status;

    // sequencer
    smpq_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_command (i_item.command),
        .i_status  (dp_status),
        .o_cmd     (dp_cmd),
        .o_busy    (busy),
        .o_done    (o_done)
    );

    // entry store and head tracking
    smpq_datapath #(
        .DEPTH     (DEPTH),
        .PRIO_BITS (PRIO_BITS),
        .ELEM_BITS (ELEM_BITS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (dp_cmd),
        .o_status (dp_status),
        .o_result (o_result)
    );

endmodule

// ===== hdl/smpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// smpq_ctrl
// Sequencer of the priority queue: decodes the command, steps the insertion
// walk and the head reload, and marks the result cycle.
// ----------------------------------------------------------------------------
module smpq_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_command,
    input  smpq_pkg::t_dp_status  i_status,
    output smpq_pkg::t_dp_cmd     o_cmd,
    output logic                  o_busy,
    output logic                  o_done
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_ENQ_CMP  = 3'd1;
    localparam logic [2:0] S_PLACE    = 3'd2;
    localparam logic [2:0] S_DEQ_LOAD = 3'd3;
    localparam logic [2:0] S_RESP     = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load_in = 1'b1;
                    if (i_command == smpq_pkg::CMD_ENQ) begin
                        if (i_status.full) begin
                            o_cmd.err_code = smpq_pkg::ERR_FULL;
                            n_state        = S_RESP;
                        end else begin
                            o_cmd.err_code = smpq_pkg::ERR_OK;
                            o_cmd.enq_init = 1'b1;
                            n_state        = i_status.empty ? S_PLACE : S_ENQ_CMP;
                        end
                    end else begin
                        if (i_status.empty) begin
                            o_cmd.err_code = smpq_pkg::ERR_EMPTY;
                            n_state        = S_RESP;
                        end else begin
                            o_cmd.err_code = smpq_pkg::ERR_OK;
                            o_cmd.deq      = 1'b1;
                            n_state        = i_status.one_left ? S_RESP : S_DEQ_LOAD;
                        end
                    end
                end
            end
            S_ENQ_CMP: begin
                // move a larger entry back, or drop the new item into the hole
                if (i_status.gt) begin
                    o_cmd.shift = 1'b1;
                    if (i_status.last) begin
                        n_state = S_PLACE;
                    end
                end else begin
                    o_cmd.place = 1'b1;
                    n_state     = S_RESP;
                end
            end
            S_PLACE: begin
                o_cmd.place = 1'b1;
                n_state     = S_RESP;
            end
            S_DEQ_LOAD: begin
                o_cmd.head_load = 1'b1;
                n_state         = S_RESP;
            end
            S_RESP: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_RESP);

endmodule

// ===== hdl/smpq_datapath.sv =====
// ----------------------------------------------------------------------------
// smpq_datapath
// Circular entry store with head pointer and count, the insertion hole
// walker, the cached head entry and the result formatting.
// ----------------------------------------------------------------------------
`include "stable_min_priority_queue_unit_assert.svh"

module smpq_datapath #(
    parameter int DEPTH     = smpq_pkg::DEPTH_DEF,
    parameter int PRIO_BITS = smpq_pkg::PRIO_BITS_DEF,
    parameter int ELEM_BITS = smpq_pkg::ELEM_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  smpq_pkg::t_in_item    i_item,
    input  smpq_pkg::t_dp_cmd     i_cmd,
    output smpq_pkg::t_dp_status  o_status,
    output smpq_pkg::t_out_item   o_result
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = AW + 1;
    localparam int MW = PRIO_BITS + ELEM_BITS;

    // entry store: {priority, element}
    logic [MW-1:0]        r_mem [DEPTH];
    logic [MW-1:0]        r_rd;

    logic [AW-1:0]        r_head, n_head;
    logic [CW-1:0]        r_count, n_count;
    logic [AW-1:0]        r_hole, n_hole;
    logic [CW-1:0]        r_left, n_left;
    logic [1:0]           r_err, n_err;
    logic [PRIO_BITS-1:0] r_prio, n_prio;
    logic [ELEM_BITS-1:0] r_elem, n_elem;
    logic [PRIO_BITS-1:0] r_head_prio, n_head_prio;
    logic [ELEM_BITS-1:0] r_head_elem, n_head_elem;

    logic [SW-1:0]        tail_sum;
    logic [AW-1:0]        tail;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [MW-1:0]        wr_data;
    logic [PRIO_BITS-1:0] rd_prio;
    logic [ELEM_BITS-1:0] rd_elem;
    logic                 is_empty;

    // circular pointer steps
    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] p);
        f_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] f_dec(input logic [AW-1:0] p);
        f_dec = (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
    endfunction

    // first free slot behind the last entry
    assign tail_sum = {1'b0, r_head} + SW'(r_count);
    assign tail     = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);

    assign rd_prio = r_rd[MW-1 -: PRIO_BITS];
    assign rd_elem = r_rd[ELEM_BITS-1:0];

    // read port address select
    always_comb begin
        rd_en = i_cmd.enq_init | i_cmd.shift | i_cmd.deq;
        if (i_cmd.deq) begin
            rd_addr = f_inc(r_head);
        end else if (i_cmd.shift) begin
            rd_addr = f_dec(f_dec(r_hole));
        end else begin
            rd_addr = f_dec(tail);
        end
    end

    // write port: shifted entry or new item into the hole
    assign wr_en   = i_cmd.shift | i_cmd.place;
    assign wr_data = i_cmd.shift ? r_rd : {r_prio, r_elem};

    // entry store access
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
        if (wr_en) begin
            r_mem[r_hole] <= wr_data;
        end
    end

    // next values
    always_comb begin
        n_head      = i_cmd.deq ? f_inc(r_head) : r_head;
        n_count     = r_count;
        n_hole      = r_hole;
        n_left      = r_left;
        n_err       = r_err;
        n_prio      = r_prio;
        n_elem      = r_elem;
        n_head_prio = r_head_prio;
        n_head_elem = r_head_elem;
        if (i_cmd.place) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.deq) begin
            n_count = r_count - CW'(1);
        end
        if (i_cmd.enq_init) begin
            n_hole = tail;
            n_left = r_count;
        end else if (i_cmd.shift) begin
            n_hole = f_dec(r_hole);
            n_left = r_left - CW'(1);
        end
        if (i_cmd.load_in) begin
            n_err  = i_cmd.err_code;
            n_prio = PRIO_BITS'(i_item.priority_req);
            n_elem = ELEM_BITS'(i_item.elem);
        end
        // new item lands at the front, or the next entry becomes head
        if (i_cmd.place && (r_left == '0)) begin
            n_head_prio = r_prio;
            n_head_elem = r_elem;
        end else if (i_cmd.head_load) begin
            n_head_prio = rd_prio;
            n_head_elem = rd_elem;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_hole  <= '0;
            r_left  <= '0;
            r_err   <= smpq_pkg::ERR_OK;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
            r_hole  <= n_hole;
            r_left  <= n_left;
            r_err   <= n_err;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_prio      <= n_prio;
        r_elem      <= n_elem;
        r_head_prio <= n_head_prio;
        r_head_elem <= n_head_elem;
    end

    // status to controller
    assign is_empty          = (r_count == '0);
    assign o_status.empty    = is_empty;
    assign o_status.full     = (r_count == CW'(DEPTH));
    assign o_status.one_left = (r_count == CW'(1));
    assign o_status.last     = (r_left == CW'(1));
    assign o_status.gt       = (rd_prio > r_prio);

    // result formatting
    assign o_result.head_elem     = is_empty ? '0 : 16'(r_head_elem);
    assign o_result.head_priority = is_empty ? '0 : 16'(r_head_prio);
    assign o_result.empty_res     = is_empty;
    assign o_result.count         = 5'(r_count);
    assign o_result.error         = r_err;

    `SMPQ_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(DEPTH))
    `SMPQ_ASSERT_IMP(a_shift_before_front, i_clk, i_rst_n, i_cmd.shift, r_left != '0)
    `SMPQ_ASSERT_IMP(a_place_has_room, i_clk, i_rst_n, i_cmd.place, !o_status.full)
    `SMPQ_ASSERT_IMP(a_reload_nonempty, i_clk, i_rst_n, i_cmd.head_load, r_count != '0)

endmodule

// ===== dv/smpq_scoreboard_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smpq_scoreboard_pkg
// Scoreboard for the stable min priority queue unit: keeps its own sorted
// copy of the queue, works out the result of each accepted item and checks
// every result against the oldest expected one.
// ----------------------------------------------------------------------------
package smpq_scoreboard_pkg;

    import smpq_pkg::*;

    class smpq_scoreboard;

        // sorted copy of the queue, head at index 0
        logic [15:0]  sorted_prio[DEPTH_DEF];
        logic [15:0]  sorted_elem[DEPTH_DEF];
        int unsigned  held;
        t_out_item    head_reports[$];
        int unsigned  mismatches;

        function new();
            held       = 0;
            mismatches = 0;
        endfunction

        function int unsigned pending();
            return head_reports.size();
        endfunction

        // apply one accepted item to the queue copy and queue its report
        function void note_item(t_in_item item);
            t_out_item rep;
            int unsigned slot;
            rep.error = ERR_OK;
            if (item.command == CMD_ENQ) begin
                if (held >= DEPTH_DEF) begin
                    rep.error = ERR_FULL;
                end else begin
                    // new entry goes behind all entries with equal or smaller priority
                    slot = 0;
                    while (slot < held && sorted_prio[slot] <= item.priority_req)
                        slot++;
                    for (int k = held; k > slot; k--) begin
                        sorted_prio[k] = sorted_prio[k-1];
                        sorted_elem[k] = sorted_elem[k-1];
                    end
                    sorted_prio[slot] = item.priority_req;
                    sorted_elem[slot] = item.elem;
                    held++;
                end
            end else begin
                if (held == 0) begin
                    rep.error = ERR_EMPTY;
                end else begin
                    for (int k = 1; k < held; k++) begin
                        sorted_prio[k-1] = sorted_prio[k];
                        sorted_elem[k-1] = sorted_elem[k];
                    end
                    held--;
                end
            end
            // head report, zeros when empty
            if (held > 0) begin
                rep.head_elem     = sorted_elem[0];
                rep.head_priority = sorted_prio[0];
                rep.empty_res     = 1'b0;
            end else begin
                rep.head_elem     = '0;
                rep.head_priority = '0;
                rep.empty_res     = 1'b1;
            end
            rep.count = 5'(held);
            head_reports.push_back(rep);
        endfunction

        // one line per mismatch
        task report_mismatch(string msg);
            $display("[%0t] MISMATCH: %s", $time, msg);
            mismatches++;
        endtask

        task compare_field(string name, int unsigned got, int unsigned want);
            if (got != want)
                report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
        endtask

        // compare a result with the oldest expected head report
        task check_result(t_out_item got);
            t_out_item want;
            if (head_reports.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected: %p", got));
            end else begin
                want = head_reports.pop_front();
                compare_field("head_elem", got.head_elem, want.head_elem);
                compare_field("head_priority", got.head_priority, want.head_priority);
                compare_field("empty_res", got.empty_res, want.empty_res);
                compare_field("count", got.count, want.count);
                compare_field("error", got.error, want.error);
            end
        endtask

    endclass

endpackage

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives enqueue and dequeue items into the priority queue unit, with a
// directed opening (extremes, ties, full and empty cases) followed by random
// phases that lean toward filling, balancing or draining the queue, and checks every
// result through the scoreboard.
// ----------------------------------------------------------------------------
module testbench;

    import smpq_pkg::*;
    import smpq_scoreboard_pkg::*;

    localparam int RANDOM_ITEMS = 1330;

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    t_in_item  i_item;
    logic      busy;
    logic      o_done;
    t_out_item o_result;

    smpq_scoreboard sb;

    stable_min_priority_queue_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #1_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // accepted items and results, sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                sb.note_item(i_item);
            if (o_done)
                sb.check_result(o_result);
        end
    end

    function automatic t_in_item make_item(logic cmd, logic [15:0] elem, logic [15:0] prio);
        t_in_item item;
        item.command      = cmd;
        item.elem         = elem;
        item.priority_req = prio;
        return item;
    endfunction

    // random item; enq_pct sets the lean toward filling the queue
    function automatic t_in_item random_item(int unsigned enq_pct);
        logic [15:0] prio;
        case ($urandom_range(0, 3))
            0, 1: prio = 16'($urandom_range(0, 7));   // many ties
            2:    prio = 16'($urandom);
            default: prio = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        endcase
        return make_item(($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ,
                         16'($urandom), prio);
    endfunction

    // present one item and wait until it is taken; while the unit is free and idling
    // is allowed, start is held low in about one cycle of four, with noise on the item bus
    task send_item(t_in_item item, bit may_idle);
        @(negedge i_clk);
        while (busy || (may_idle && $urandom_range(0, 99) < 25)) begin
            start  <= 1'b0;
            i_item <= make_item(1'($urandom), 16'($urandom), 16'($urandom));
            @(negedge i_clk);
        end
        start  <= 1'b1;
        i_item <= item;
        @(posedge i_clk);
    endtask

    // stop sending until every expected result has come
    task drain_wait();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
    endtask

    initial begin
        logic [15:0] fill_prio[16];
        int unsigned sent;
        int unsigned phase_len;
        int unsigned enq_pct;
        int unsigned waited;

        sb = new();
        fill_prio = '{16'hFFFF, 16'h0000, 16'h0007, 16'h0007, 16'h0007, 16'h0000,
                      16'hFFFF, 16'h0003, 16'h8000, 16'h7FFF, 16'h0007, 16'h0001,
                      16'hFFFE, 16'h0000, 16'h0007, 16'h0002};
        start   = 1'b0;
        i_item  = '0;
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: dequeue on empty, fill with extremes and ties, enqueue on full, then dequeues and a tied enqueue
        send_item(make_item(CMD_DEQ, 16'hFFFF, 16'hFFFF), 1'b0);
        for (int i = 0; i < 16; i++) begin
            send_item(make_item(CMD_ENQ, (i == 0) ? 16'hFFFF : (i == 1) ? 16'h0000 :
                                16'($urandom), fill_prio[i]), 1'b0);
        end
        send_item(make_item(CMD_ENQ, 16'hBEEF, 16'h0000), 1'b0);
        repeat (4) send_item(make_item(CMD_DEQ, 16'($urandom), 16'($urandom)), 1'b0);
        send_item(make_item(CMD_ENQ, 16'h1234, 16'h0007), 1'b0);
        drain_wait();

        // random phases leaning toward fill, balance or drain
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            phase_len = $urandom_range(20, 60);
            case ($urandom_range(0, 2))
                0: enq_pct = 85;
                1: enq_pct = 50;
                default: enq_pct = 15;
            endcase
            repeat (phase_len) begin
                // no idling through the middle stretch
                send_item(random_item(enq_pct), !(sent >= 500 && sent < 800));
                sent++;
                if (sent % 300 == 0)
                    drain_wait();
            end
        end

        // wait for the last results
        @(negedge i_clk);
        start <= 1'b0;
        waited = 0;
        while (sb.pending() != 0 && waited < 2000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (40) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            if (sb.pending() != 0)
                $display("%0d expected results never arrived", sb.pending());
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== stable_min_priority_queue_unit.f =====
+incdir+hdl
hdl/smpq_pkg.sv
hdl/smpq_ctrl.sv
hdl/smpq_datapath.sv
hdl/stable_min_priority_queue_unit.sv
dv/smpq_scoreboard_pkg.sv
dv/testbench.sv
